>>> src/window_peak_to_peak_tracker_macros.svh
// Assertion macros for the checker of the peak-to-peak tracker.
`ifndef WINDOW_PEAK_TO_PEAK_TRACKER_MACROS_SVH
`define WINDOW_PEAK_TO_PEAK_TRACKER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge and off during reset.
`define WPPT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge and off during reset.
`define WPPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/wppt_pkg.sv
// Shared field widths of the peak-to-peak tracker.
package wppt_pkg;
	localparam int CHANNEL_W = 4;
	localparam int SAMPLE_W  = 14;
	localparam int P2P_W     = 14;
	localparam int FILL_W    = 8;
endpackage

>>> src/wppt_if.sv
// Request channels of the peak-to-peak tracker: sample input and result output.
interface wppt_in_if;
	logic                           valid;
	logic                           ready;
	logic [wppt_pkg::CHANNEL_W-1:0] channel;
	logic [wppt_pkg::SAMPLE_W-1:0]  sample;
	logic                           frame_end;

	modport source (output valid, channel, sample, frame_end, input ready);
	modport sink (input valid, channel, sample, frame_end, output ready);
endinterface

interface wppt_out_if;
	logic                        valid;
	logic                        ready;
	logic [wppt_pkg::P2P_W-1:0]  span;
	logic [wppt_pkg::FILL_W-1:0] window_fill;

	modport source (output valid, span, window_fill, input ready);
	modport sink (input valid, span, window_fill, output ready);
endinterface

>>> src/window_peak_to_peak_tracker.sv
// Per-channel sliding window peak-to-peak tracker built around one sample memory.
// Each accepted request writes its sample to memory, then scans the used window entries of its channel,
// used being the number of window entries in use (1 to WINDOW), one memory read per entry, and keeps
// their minimum and maximum; an absent channel skips the write and the scan, giving zero span and fill.
// No new request is taken until the result is registered; that waits for a free output.
// Reset clears the write position, the fill count and all control; the sample memory is kept.
module window_peak_to_peak_tracker #(
	parameter int CHANNELS    = 14,
	parameter int WINDOW      = 128,
	parameter int SAMPLE_BITS = 14
) (
	input  logic       clk,
	input  logic       arst_n,
	wppt_in_if.sink    samples,
	wppt_out_if.source results
);
	localparam int IDX_W = $clog2(WINDOW);
	localparam int CNT_W = $clog2(WINDOW + 1);
	localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int ADDR_W = CH_W + IDX_W;
	localparam int DEPTH  = 2 ** ADDR_W;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_WRITE = 4'b0010,
		ST_SCAN  = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t                 state_q;
	logic [IDX_W-1:0]       pos_q;
	logic [CNT_W-1:0]       fill_q;
	logic [CH_W-1:0]        ch_q;
	logic [SAMPLE_BITS-1:0] sample_q;
	logic [IDX_W-1:0]       wpos_q;
	logic [CNT_W-1:0]       used_q;
	logic [CNT_W-1:0]       issue_q;
	logic                   rd_vld_s1;
	logic                   rd_first_s1;
	logic [SAMPLE_BITS-1:0] rd_data_s1;
	logic [SAMPLE_BITS-1:0] lo_q;
	logic [SAMPLE_BITS-1:0] hi_q;
	logic                   out_valid_q;
	logic [wppt_pkg::P2P_W-1:0]  out_p2p_q;
	logic [wppt_pkg::FILL_W-1:0] out_fill_q;

	logic [SAMPLE_BITS-1:0] mem [DEPTH];

	logic                   accept;
	logic                   ch_ok;
	logic [CNT_W-1:0]       used_now;
	logic                   mem_we;
	logic                   mem_re;
	logic [ADDR_W-1:0]      mem_addr;
	logic                   out_free;

	assign accept   = samples.valid && samples.ready;
	assign ch_ok    = int'(samples.channel) < CHANNELS;
	assign used_now = (fill_q < CNT_W'(WINDOW)) ? fill_q + CNT_W'(1) : CNT_W'(WINDOW);
	assign out_free = !out_valid_q || results.ready;

	assign samples.ready       = (state_q == ST_IDLE);
	assign results.valid       = out_valid_q;
	assign results.span        = out_p2p_q;
	assign results.window_fill = out_fill_q;

	assign mem_we   = (state_q == ST_WRITE);
	assign mem_re   = (state_q == ST_SCAN) && (issue_q < used_q);
	assign mem_addr = mem_we ? {ch_q, wpos_q} : {ch_q, issue_q[IDX_W-1:0]};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= sample_q;
		end
		rd_data_s1 <= mem[mem_addr];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q     <= CH_W'(samples.channel);
			sample_q <= SAMPLE_BITS'(samples.sample);
			wpos_q   <= pos_q;
		end
		if (rd_vld_s1) begin
			if (rd_first_s1) begin
				lo_q <= rd_data_s1;
				hi_q <= rd_data_s1;
			end else begin
				if (rd_data_s1 < lo_q) begin
					lo_q <= rd_data_s1;
				end
				if (rd_data_s1 > hi_q) begin
					hi_q <= rd_data_s1;
				end
			end
		end else if (accept) begin
			lo_q <= '0;
			hi_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			fill_q      <= '0;
			used_q      <= '0;
			issue_q     <= '0;
			rd_vld_s1   <= 1'b0;
			rd_first_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			out_p2p_q   <= '0;
			out_fill_q  <= '0;
		end else begin
			rd_vld_s1   <= mem_re;
			rd_first_s1 <= mem_re && (issue_q == '0);
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						used_q  <= ch_ok ? used_now : '0;
						issue_q <= '0;
						state_q <= ch_ok ? ST_WRITE : ST_DONE;
						if (samples.frame_end) begin
							pos_q <= (pos_q == IDX_W'(WINDOW - 1)) ? '0 : pos_q + IDX_W'(1);
							if (fill_q < CNT_W'(WINDOW)) begin
								fill_q <= fill_q + CNT_W'(1);
							end
						end
					end
				end
				ST_WRITE: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (mem_re) begin
						issue_q <= issue_q + CNT_W'(1);
					end else if (!rd_vld_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_p2p_q  <= wppt_pkg::P2P_W'(hi_q - lo_q);
						out_fill_q <= wppt_pkg::FILL_W'(used_q);
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

>>> src/wppt_checker.sv
// Port-level checker of the peak-to-peak tracker and its bind to the top level.
`include "window_peak_to_peak_tracker_macros.svh"

module wppt_checker #(
	parameter int WINDOW = 128
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [wppt_pkg::P2P_W-1:0]  span,
	input logic [wppt_pkg::FILL_W-1:0] window_fill
);
	`WPPT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(span) && $stable(window_fill), "Stalled result changed.")
	`WPPT_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, in_valid && in_ready, !in_ready, "Request accepted while the previous one is still in work.")
	`WPPT_ASSERT_NOW(a_fill_range, clk, arst_n, out_valid, int'(window_fill) <= WINDOW, "Window fill exceeds the window length.")
	`WPPT_ASSERT_NOW(a_single_entry, clk, arst_n, out_valid && (window_fill == 8'd0 || window_fill == 8'd1), span == '0, "Nonzero peak-to-peak over fewer than two entries.")
endmodule

bind window_peak_to_peak_tracker wppt_checker #(
	.WINDOW(WINDOW)
) u_wppt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (samples.valid),
	.in_ready    (samples.ready),
	.out_valid   (results.valid),
	.out_ready   (results.ready),
	.span        (results.span),
	.window_fill (results.window_fill)
);
